### rtl/assert_macros.svh
// Assertion macros shared by the RTL. Synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

### rtl/lfr_pkg.sv
`default_nettype none

package lfr_pkg;

  // Operation codes carried in the input item.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Reset value of the saturation bound, about 0.99 of full scale.
  localparam logic [30:0] CLAMP_RESET = 31'd2126008810;

  // The sum of Q1.31 by Q1.31 products is Q2.62; this shift brings it back to Q1.31.
  localparam int FRAC_SHIFT = 31;

  typedef struct packed {
    logic               operation;
    logic [9:0]         tap_index;
    logic signed [31:0] tap_value;
    logic signed [31:0] audio_in;
  } lfr_in_t;

  typedef struct packed {
    logic signed [31:0] wet_out;
    logic               clipped;
  } lfr_out_t;

endpackage

`default_nettype wire

### rtl/long_fir_reverb_core.sv
`default_nettype none
`include "assert_macros.svh"

// Channel   Direction  Handshake               Carries
// in        input      in_valid / in_ready     lfr_in_t: tap load or audio sample
// out       output     out_valid / out_ready   lfr_out_t: wet sample and clip flag
// cfg       input      cfg_valid / cfg_ready   31-bit saturation bound
//
// After reset the sample history is swept to zero, one entry per cycle; the
// input channel is not ready during that sweep, configuration is.
// A sample is summed by the single shared 32x32 multiplier and accumulator,
// visiting one tap per cycle.
// The finished sample sits in an output register, so the next item is accepted while
// it waits; a sample whose result is ready waits only if that register is still full.

module long_fir_reverb_core #(
  parameter int TAPS        = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  lfr_pkg::lfr_in_t  in_data,
  output logic              out_valid,
  input  wire               out_ready,
  output lfr_pkg::lfr_out_t result,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire [30:0]        cfg_data
);

  import lfr_pkg::*;

  localparam int AW        = $clog2(TAPS);
  // Each product fits in 64 bits; TAPS of them need AW more bits for an exact sum.
  localparam int ACC_W     = 64 + AW;
  localparam int SW        = ACC_W - FRAC_SHIFT;
  localparam int SMP_SHIFT = 32 - SAMPLE_BITS;
  localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_SAT
  } state_t;

  state_t state;

  // Tap and history memories, each one write and one registered read per cycle.
  logic signed [31:0] tap_mem  [TAPS];
  logic signed [31:0] hist_mem [TAPS];
  logic signed [31:0] tap_rd;
  logic signed [31:0] hist_rd;

  logic [AW-1:0]      k;      // tap being read, or entry being cleared
  logic [AW-1:0]      idx;    // history entry paired with tap k
  logic [AW-1:0]      ptr;    // where the next sample goes
  logic               v1;     // read data valid
  logic               v2;     // product valid
  logic signed [63:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic [30:0]        clamp;

  logic               accept;
  logic               tap_we;
  logic               hist_we;
  logic [AW-1:0]      hist_wa;
  logic signed [31:0] hist_wd;
  logic signed [31:0] sample;
  logic signed [SW-1:0] shifted;
  logic signed [SW-1:0] lim_hi;
  logic signed [SW-1:0] lim_lo;
  logic signed [31:0] lim_pos;
  logic signed [31:0] lim_neg;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // The low SAMPLE_BITS bits are a two's complement sample, left-justified to Q1.31.
  assign sample = $signed(32'(in_data.audio_in) << SMP_SHIFT);

  assign tap_we  = accept && (in_data.operation == OP_LOAD)
                   && (32'(in_data.tap_index) < 32'(TAPS));
  assign hist_we = (state == S_CLEAR) || (accept && (in_data.operation == OP_SAMPLE));
  assign hist_wa = (state == S_CLEAR) ? k : ptr;
  assign hist_wd = (state == S_CLEAR) ? 32'sd0 : sample;

  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[AW'(in_data.tap_index)] <= in_data.tap_value;
    end
    tap_rd <= tap_mem[k];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_rd <= hist_mem[idx];
  end

  // The shared multiplier, registered before the accumulator.
  always_ff @(posedge clk) begin
    prod <= tap_rd * hist_rd;
  end

  // Floor shift of the exact sum, then a symmetric clamp.
  assign shifted = acc[ACC_W-1:FRAC_SHIFT];
  assign lim_hi  = $signed({{(SW-31){1'b0}}, clamp});
  assign lim_lo  = -lim_hi;
  assign lim_pos = $signed({1'b0, clamp});
  assign lim_neg = -lim_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      k         <= '0;
      idx       <= '0;
      ptr       <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
      clamp     <= CLAMP_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        clamp <= cfg_data;
      end

      v1 <= (state == S_RUN);
      v2 <= v1;
      if (v2) begin
        acc <= acc + {{(ACC_W-64){prod[63]}}, prod};
      end

      // In the saturation step the output register is refilled below instead.
      if (out_valid && out_ready && (state != S_SAT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          if (k == LAST) begin
            k     <= '0;
            state <= S_IDLE;
          end else begin
            k <= k + AW'(1);
          end
        end
        S_IDLE: begin
          if (accept && (in_data.operation == OP_SAMPLE)) begin
            k     <= '0;
            idx   <= ptr;
            acc   <= '0;
            ptr   <= (ptr == LAST) ? '0 : ptr + AW'(1);
            state <= S_RUN;
          end
        end
        S_RUN: begin
          idx <= (idx == '0) ? LAST : idx - AW'(1);
          if (k == LAST) begin
            k     <= '0;
            state <= S_DRAIN;
          end else begin
            k <= k + AW'(1);
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2) begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            if (shifted > lim_hi) begin
              result.wet_out <= lim_pos;
              result.clipped <= 1'b1;
            end else if (shifted < lim_lo) begin
              result.wet_out <= lim_neg;
              result.clipped <= 1'b1;
            end else begin
              result.wet_out <= shifted[31:0];
              result.clipped <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Products only flow while a sample is being summed.
  `ASSERT_PROP(a_prod_in_run, clk, rst, v2 |-> (state == S_RUN || state == S_DRAIN), "product outside a sum")
  // The result is formed only once the pipeline has emptied into the accumulator.
  `ASSERT_NEVER(a_sat_early, clk, rst, (state == S_SAT) && (v1 || v2), "saturation before drain")
  // A new result only comes from the saturation step.
  `ASSERT_PROP(a_out_source, clk, rst, $rose(out_valid) |-> $past(state) == S_SAT, "result from nowhere")
  // A flagged result always sits exactly on the bound.
  `ASSERT_PROP(a_clip_value, clk, rst, (out_valid && result.clipped) |-> (result.wet_out == lim_pos || result.wet_out == lim_neg), "clipped value off the bound")

endmodule

`default_nettype wire

### tb/sv/long_fir_reverb_checker.sv
`timescale 1ns / 1ps

module long_fir_reverb_checker #(
  parameter int TAPS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  lfr_pkg::lfr_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  lfr_pkg::lfr_out_t result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [30:0]       cfg_data,
  output int                fail_count,
  output int                results_pending
);

  import lfr_pkg::*;

  logic signed [31:0] ir_taps [TAPS];
  logic signed [31:0] history [TAPS];
  int unsigned        newest_slot;
  logic [30:0]        bound;
  lfr_out_t           wet_expected [$];
  lfr_out_t           oldest;
  int                 errors = 0;

  // Shifts one sample into the history and returns the saturated wet sample.
  function automatic lfr_out_t convolve_sample(input logic signed [31:0] x);
    logic signed [79:0] acc;
    logic signed [63:0] prod;
    logic signed [48:0] scaled;
    logic signed [48:0] lim;
    int unsigned        pos;
    lfr_out_t           res;
    history[newest_slot] = x;
    acc = '0;
    pos = newest_slot;
    for (int k = 0; k < TAPS; k++) begin
      prod = ir_taps[k] * history[pos];
      acc  = acc + prod;
      pos  = (pos == 0) ? TAPS - 1 : pos - 1;
    end
    newest_slot = (newest_slot == TAPS - 1) ? 0 : newest_slot + 1;
    // Floor shift of the Q2.62 sum back to Q1.31.
    scaled = acc[79:31];
    lim    = {18'b0, bound};
    if (scaled > lim) begin
      res.wet_out = {1'b0, bound};
      res.clipped = 1'b1;
    end else if (scaled < -lim) begin
      res.wet_out = -$signed({1'b0, bound});
      res.clipped = 1'b1;
    end else begin
      res.wet_out = scaled[31:0];
      res.clipped = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        ir_taps[i] = '0;
        history[i] = '0;
      end
      newest_slot = 0;
      bound       = CLAMP_RESET;
      wet_expected.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        bound = cfg_data;
      end
      // Results are checked before new items are predicted, so an item
      // accepted at this edge can never satisfy a result leaving at it.
      if (out_valid && out_ready) begin
        if (wet_expected.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected wet sample %0d (clip %0b) with none pending",
                     result.wet_out, result.clipped);
          end
        end else begin
          oldest = wet_expected.pop_front();
          if (result.wet_out !== oldest.wet_out || result.clipped !== oldest.clipped) begin
            errors++;
            if (errors <= 10) begin
              $display("wet sample mismatch: expected %0d (clip %0b), got %0d (clip %0b)",
                       oldest.wet_out, oldest.clipped, result.wet_out, result.clipped);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.operation == OP_LOAD) begin
          ir_taps[in_data.tap_index] = in_data.tap_value;
        end else begin
          wet_expected.push_back(convolve_sample(in_data.audio_in));
        end
      end
    end
    fail_count      <= errors;
    results_pending <= wet_expected.size();
  end

endmodule

### tb/sv/tb_long_fir_reverb_core.sv
`timescale 1ns / 1ps

module tb_long_fir_reverb_core;
  import lfr_pkg::*;

  localparam int TAPS = 1024;

  // The worst correct run (hardware sweep, 1024 preamble loads, up to some
  // 460 samples with the longest stalls and gaps, and every drain) stays
  // under this limit.
  localparam int unsigned CYCLE_LIMIT = 2_500_000;

  localparam logic signed [31:0] Q31_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q31_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] Q31_HALF = 32'sh4000_0000;

  localparam int PHASES         = 6;
  localparam int ITEMS_PER_PHASE = 75;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  lfr_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  lfr_out_t    result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [30:0] cfg_data = '0;

  int          fail_count;
  int          results_pending;

  // When set, both the sender and the receiver insert random idle bursts.
  logic        idle_enable = 1'b0;
  int          stall_left = 0;
  int unsigned cycle_count = 0;

  logic [30:0] clamp_plan [PHASES];

  always #1 clk = ~clk;

  long_fir_reverb_core #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (32)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  long_fir_reverb_checker #(
    .TAPS (TAPS)
  ) i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result          (result),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  // Receiver side. A stall burst starts now and then; the cycle that starts
  // it is part of the burst. Between bursts the receiver takes every wet
  // sample at once.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_enable && $urandom_range(0, 15) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: a hung handshake or a wet sample that never arrives ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Random Q1.31 word. Zero and both extremes come up often; otherwise a
  // random word is scaled down by an arithmetic shift so that sums land on
  // both sides of the saturation bound.
  function automatic logic signed [31:0] random_q31(input int min_shift);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return Q31_MAX;
      2:       return Q31_MIN;
      default: return $signed($urandom) >>> $urandom_range(min_shift, 31);
    endcase
  endfunction

  // Presents one item and holds it until the block takes it. Valid is left
  // high after the handshake; it is lowered only at the start of an idle gap
  // or a drain, so it never gets two assignments in one time step.
  task automatic send_item(input lfr_in_t item);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Tap load. The audio field is ignored by the block, so it carries noise.
  task automatic load_tap(input int unsigned index, input logic signed [31:0] value);
    lfr_in_t item;
    item.operation = OP_LOAD;
    item.tap_index = index[9:0];
    item.tap_value = value;
    item.audio_in  = $urandom;
    send_item(item);
  endtask

  // Audio sample. The tap fields are ignored, so they carry noise.
  task automatic play_sample(input logic signed [31:0] value);
    lfr_in_t item;
    item.operation = OP_SAMPLE;
    item.tap_index = 10'($urandom_range(0, TAPS - 1));
    item.tap_value = $urandom;
    item.audio_in  = value;
    send_item(item);
  endtask

  // Stops sending and waits until every wet sample has been taken, then for
  // longer than a sample takes, since a trailing tap load leaves nothing to
  // wait for but may still be in flight.
  task automatic wait_until_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (TAPS + 16) @(posedge clk);
  endtask

  // The bound is written while idle, but for the first write during the sweep.
  task automatic write_clamp(input logic [30:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst         <= 1'b0;
    idle_enable <= 1'b1;

    // A small bound makes exact hits easy to build. It is written while the
    // block still sweeps its history, where the config channel is open.
    write_clamp(31'd1000);

    // Every tap is loaded before the first sample, so no unwritten tap is
    // ever read. Tap 0 is one half and all others are zero, which turns the
    // filter into a floor division by two.
    for (int i = 0; i < TAPS; i++) begin
      load_tap(i, (i == 0) ? Q31_HALF : 32'sd0);
    end

    // Halves land exactly on the bound and just past it on both sides, then
    // the floor behavior around zero.
    play_sample(32'sd2000);
    play_sample(32'sd2002);
    play_sample(-32'sd2000);
    play_sample(-32'sd2002);
    play_sample(32'sd1);
    play_sample(-32'sd1);
    play_sample(32'sd0);

    // Zero bound: a zero sum passes clean, anything else becomes a flagged 0.
    wait_until_quiet();
    write_clamp(31'd0);
    play_sample(32'sd0);
    play_sample(32'sd5);
    play_sample(-32'sd5);

    // Widest bound with extreme taps at index 1, the middle and the last index.
    // A full-scale positive sample after two full-scale negative ones drives
    // the sum past anything a 32-bit result can hold, so even the widest
    // bound clips.
    wait_until_quiet();
    write_clamp(31'h7FFF_FFFF);
    load_tap(1, Q31_MIN);
    load_tap(512, Q31_MAX);
    load_tap(TAPS - 1, Q31_MIN);
    play_sample(Q31_MIN);
    play_sample(Q31_MIN);
    play_sample(Q31_MAX);
    load_tap(1, 32'sd0);
    load_tap(512, 32'sd0);
    load_tap(TAPS - 1, 32'sd0);

    // Random phases, one bound each: reset value, both extremes, the
    // smallest nonzero bound, and two random ones. Each phase starts from an
    // idle filter, which also gives the sender its full pause. The last
    // phase runs without any idle bursts.
    clamp_plan[0] = CLAMP_RESET;
    clamp_plan[1] = 31'h7FFF_FFFF;
    clamp_plan[2] = 31'd1;
    clamp_plan[3] = 31'd0;
    clamp_plan[4] = 31'($urandom);
    clamp_plan[5] = 31'($urandom >> $urandom_range(1, 30));

    for (int p = 0; p < PHASES; p++) begin
      wait_until_quiet();
      write_clamp(clamp_plan[p]);
      idle_enable <= (p < PHASES - 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Taps are kept a little smaller than samples so that the growing
        // set of random taps does not push every sum into saturation.
        if ($urandom_range(0, 9) < 3) begin
          load_tap($urandom_range(0, TAPS - 1), random_q31(4));
        end else begin
          play_sample(random_q31(0));
        end
      end
    end

    wait_until_quiet();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
